### rtl/core/lps_pkg.sv
// Package for the LED pattern sequencer: mode, phase, operation and register
// codes, step timings, and the shared register and state structs.
// Depends on nothing; every other file of the block but lps_if imports it.
package lps_pkg;

	// Operation codes of an input request.
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_SET_MODE = 2'd1;
	localparam logic [1:0] OP_SHOW_CODE = 2'd2;

	// Mode codes.
	localparam logic [2:0] M_OFF = 3'd0;
	localparam logic [2:0] M_ON = 3'd1;
	localparam logic [2:0] M_BREATHE = 3'd2;
	localparam logic [2:0] M_CODE = 3'd3;
	localparam logic [2:0] M_USER = 3'd4;
	localparam logic [2:0] M_DONE = 3'd5;

	// Phase codes of the running pattern.
	localparam logic [2:0] PH_UP = 3'd0;
	localparam logic [2:0] PH_TOP = 3'd1;
	localparam logic [2:0] PH_DOWN = 3'd2;
	localparam logic [2:0] PH_PAUSE = 3'd3;
	localparam logic [2:0] PH_ON = 3'd4;
	localparam logic [2:0] PH_OFF = 3'd5;
	localparam logic [2:0] PH_DARK = 3'd6;

	// Step lengths in milliseconds.
	localparam logic [15:0] RAMP_MS = 16'd10;
	localparam logic [15:0] HOLD_MS = 16'd250;
	localparam logic [15:0] DARK_MS = 16'd500;
	localparam logic [15:0] FLASH_ON_MS = 16'd250;
	localparam logic [15:0] FLASH_OFF_MS = 16'd200;
	localparam logic [1:0] PASSES = 2'd3;

	// Brightness limit in percent.
	localparam logic [6:0] PCT_MAX = 7'd100;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_MAX_LIGHT = 2'd0;
	localparam logic [1:0] REG_USER_PERIOD = 2'd1;
	localparam logic [1:0] REG_DIMMING = 2'd2;
	localparam logic [1:0] REG_RELOAD = 2'd3;
	localparam int ADDR_W = 4;

	// Register reset values.
	localparam logic [6:0] MAX_LIGHT_RST = 7'd80;
	localparam logic [15:0] RELOAD_RST = 16'd999;

	// Divide by 100: multiply by floor(2^22 / 100), then one correction step.
	localparam logic [15:0] PCT_RECIP = 16'd41943;
	localparam int RECIP_SHIFT = 22;
	localparam int PROD_W = 23;
	localparam int RPROD_W = PROD_W + 16;
	localparam int QUOT_W = RPROD_W - RECIP_SHIFT;

	typedef struct packed {
		logic [6:0] max_light;
		logic [15:0] user_period;
		logic dimming;
		logic [15:0] reload;
	} cfg_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [2:0] phase;
		logic [6:0] ramp_level;
		logic [15:0] ms_counter;
		logic [1:0] pass_count;
		logic [7:0] flash_count;
		logic [7:0] code_value;
		logic [6:0] level_now;
	} seq_state_t;

	// Result of the sequencer for one request, before PWM scaling.
	typedef struct packed {
		logic [6:0] level;
		logic done;
	} seq_res_t;

endpackage

### rtl/core/lps_if.sv
// Request and result channel interfaces of the LED pattern sequencer.
// Depends on nothing; carries valid, ready and the payload fields.
interface lps_in_if;
	logic valid;
	logic ready;
	logic [1:0] operation;
	logic [2:0] mode;
	logic [7:0] code;

	modport source (output valid, output operation, output mode, output code, input ready);
	modport sink (input valid, input operation, input mode, input code, output ready);
endinterface

interface lps_out_if;
	logic valid;
	logic ready;
	logic [6:0] duty_percent;
	logic [15:0] compare_value;
	logic ready_res;

	modport source (output valid, output duty_percent, output compare_value,
		output ready_res, input ready);
	modport sink (input valid, input duty_percent, input compare_value,
		input ready_res, output ready);
endinterface

### rtl/core/lps_cfg.sv
// APB-style configuration registers of the LED pattern sequencer.
// Depends on lps_pkg for register indexes, reset values and cfg_t.
module lps_cfg (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [lps_pkg::ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output lps_pkg::cfg_t cfg
);
	import lps_pkg::*;

	cfg_t cfg_q;
	logic wr_en;
	logic [1:0] reg_idx;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg = cfg_q;

	// Register writes on the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_light <= MAX_LIGHT_RST;
			cfg_q.user_period <= '0;
			cfg_q.dimming <= 1'b0;
			cfg_q.reload <= RELOAD_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MAX_LIGHT: cfg_q.max_light <= pwdata[6:0];
				REG_USER_PERIOD: cfg_q.user_period <= pwdata[15:0];
				REG_DIMMING: cfg_q.dimming <= pwdata[0];
				REG_RELOAD: cfg_q.reload <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register.
	always_comb begin
		case (reg_idx)
			REG_MAX_LIGHT: prdata = {25'd0, cfg_q.max_light};
			REG_USER_PERIOD: prdata = {16'd0, cfg_q.user_period};
			REG_DIMMING: prdata = {31'd0, cfg_q.dimming};
			REG_RELOAD: prdata = {16'd0, cfg_q.reload};
			default: prdata = '0;
		endcase
	end

endmodule

### rtl/core/lps_seq.sv
// Pattern state machine of the LED pattern sequencer: applies one request per
// ready cycle to the sequence state and registers the resulting level. Uses lps_pkg.
module lps_seq (
	input logic clk,
	input logic arst_n,
	lps_in_if.sink in_ch,
	input lps_pkg::cfg_t cfg,
	input logic next_ready,
	output logic res_valid,
	output lps_pkg::seq_res_t res
);
	import lps_pkg::*;

	seq_state_t st_q;
	seq_state_t st_nx;
	logic valid_s1;
	seq_res_t res_s1;
	logic accept;
	logic [6:0] top;
	logic [15:0] uwait;

	// Effective brightness limit and user wait time.
	assign top = (cfg.max_light > PCT_MAX) ? PCT_MAX : cfg.max_light;
	assign uwait = (cfg.user_period == '0) ? 16'd1 : cfg.user_period;

	function automatic seq_state_t set_step(seq_state_t s, logic [2:0] ph, logic [15:0] ms);
		s.phase = ph;
		s.ms_counter = ms;
		return s;
	endfunction

	function automatic seq_state_t hold_bottom(seq_state_t s, logic [15:0] uw);
		return set_step(s, PH_PAUSE, (s.mode == M_USER) ? uw : HOLD_MS);
	endfunction

	function automatic seq_state_t start_down(seq_state_t s, logic [6:0] tp, logic [15:0] uw);
		s.ramp_level = tp;
		if (tp != '0) begin
			s.level_now = tp;
			s = set_step(s, PH_DOWN, RAMP_MS);
		end else begin
			s = hold_bottom(s, uw);
		end
		return s;
	endfunction

	function automatic seq_state_t after_up(seq_state_t s, logic [6:0] tp, logic [15:0] uw);
		if (s.mode == M_USER) begin
			s = start_down(s, tp, uw);
		end else begin
			s = set_step(s, PH_TOP, HOLD_MS);
		end
		return s;
	endfunction

	function automatic seq_state_t start_cycle(seq_state_t s, logic [6:0] tp, logic [15:0] uw,
			logic dim);
		if (s.mode == M_USER && !dim) begin
			s.level_now = tp;
			s = set_step(s, PH_ON, uw);
		end else begin
			s.ramp_level = '0;
			if (tp != '0) begin
				s.level_now = '0;
				s = set_step(s, PH_UP, RAMP_MS);
			end else begin
				s = after_up(s, tp, uw);
			end
		end
		return s;
	endfunction

	function automatic seq_state_t start_pass(seq_state_t s);
		s.flash_count = '0;
		return set_step(s, PH_DARK, DARK_MS);
	endfunction

	function automatic seq_state_t next_flash(seq_state_t s, logic [6:0] tp);
		if (s.flash_count < s.code_value) begin
			s.level_now = tp;
			s = set_step(s, PH_ON, FLASH_ON_MS);
		end else begin
			s.pass_count = s.pass_count + 2'd1;
			if (s.pass_count >= PASSES) begin
				s.mode = M_DONE;
				s = set_step(s, PH_UP, '0);
			end else begin
				s = start_pass(s);
			end
		end
		return s;
	endfunction

	function automatic seq_state_t start_mode(seq_state_t s, logic [6:0] tp, logic [15:0] uw,
			logic dim);
		case (s.mode)
			M_OFF: begin
				s.level_now = '0;
				s.mode = M_DONE;
			end
			M_ON: begin
				s.level_now = tp;
				s.mode = M_DONE;
			end
			M_BREATHE, M_USER: s = start_cycle(s, tp, uw, dim);
			M_CODE: begin
				s.level_now = '0;
				s.pass_count = '0;
				s = start_pass(s);
			end
			default: ;
		endcase
		return s;
	endfunction

	function automatic seq_state_t step_end(seq_state_t s, logic [6:0] tp, logic [15:0] uw,
			logic dim);
		if (s.mode == M_CODE) begin
			if (s.phase == PH_DARK) begin
				s = next_flash(s, tp);
			end else if (s.phase == PH_ON) begin
				s.level_now = '0;
				s = set_step(s, PH_OFF, FLASH_OFF_MS);
			end else begin
				s.flash_count = s.flash_count + 8'd1;
				s = next_flash(s, tp);
			end
		end else begin
			case (s.phase)
				PH_UP: begin
					s.ramp_level = s.ramp_level + 7'd1;
					if (s.ramp_level < tp) begin
						s.level_now = s.ramp_level;
						s = set_step(s, PH_UP, RAMP_MS);
					end else begin
						s = after_up(s, tp, uw);
					end
				end
				PH_TOP: s = start_down(s, tp, uw);
				PH_DOWN: begin
					s.ramp_level = s.ramp_level - 7'd1;
					if (s.ramp_level != '0) begin
						s.level_now = s.ramp_level;
						s = set_step(s, PH_DOWN, RAMP_MS);
					end else begin
						s = hold_bottom(s, uw);
					end
				end
				PH_ON: begin
					s.level_now = '0;
					s = set_step(s, PH_OFF, uw);
				end
				default: s = start_cycle(s, tp, uw, dim);
			endcase
		end
		return s;
	endfunction

	// Next state for the request on the channel.
	always_comb begin
		st_nx = st_q;
		case (in_ch.operation)
			OP_TICK: begin
				if (st_q.mode == M_OFF || st_q.mode == M_ON) begin
					st_nx = start_mode(st_nx, top, uwait, cfg.dimming);
				end else if (st_q.mode == M_BREATHE || st_q.mode == M_CODE ||
						st_q.mode == M_USER) begin
					if (st_nx.ms_counter != '0) begin
						st_nx.ms_counter = st_nx.ms_counter - 16'd1;
					end
					if (st_nx.ms_counter == '0) begin
						st_nx = step_end(st_nx, top, uwait, cfg.dimming);
					end
				end
			end
			OP_SET_MODE: begin
				st_nx.mode = in_ch.mode;
				st_nx = start_mode(st_nx, top, uwait, cfg.dimming);
			end
			OP_SHOW_CODE: begin
				st_nx.mode = M_CODE;
				st_nx.code_value = in_ch.code;
				st_nx = start_mode(st_nx, top, uwait, cfg.dimming);
			end
			default: ;
		endcase
	end

	assign in_ch.ready = !valid_s1 || next_ready;
	assign accept = in_ch.valid && in_ch.ready;

	// Sequence state and the first pipeline stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{mode: M_OFF, default: '0};
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				st_q <= st_nx;
			end
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1.level <= st_nx.level_now;
			res_s1.done <= (st_nx.mode == M_DONE);
		end
	end

	assign res_valid = valid_s1;
	assign res = res_s1;

endmodule

### rtl/core/lps_scale.sv
// PWM compare scaling pipeline: reload * level / 100 over three stages, the last
// being the output register that drives the result channel. Uses lps_pkg.
module lps_scale (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input lps_pkg::seq_res_t res,
	input logic [15:0] reload,
	output logic res_ready,
	lps_out_if.source out_ch
);
	import lps_pkg::*;

	logic valid_s2, valid_s3, valid_s4;
	logic rdy2, rdy3, rdy4;
	seq_res_t res_s2, res_s3, res_s4;
	logic [PROD_W-1:0] prod_s2, prod_s3;
	logic [QUOT_W-1:0] quot_s3;
	logic [RPROD_W-1:0] rprod;
	logic [PROD_W:0] rem;
	logic [QUOT_W-1:0] quot_fix;
	logic [15:0] cmp_s4;

	// Each stage moves when it is empty or the next one moves.
	assign rdy4 = !valid_s4 || out_ch.ready;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign res_ready = rdy2;

	// Estimate of the quotient; it is exact or one too small.
	assign rprod = RPROD_W'(prod_s2) * RPROD_W'(PCT_RECIP);

	// Remainder check corrects the estimate.
	assign rem = (PROD_W+1)'(prod_s3) - ((PROD_W+1)'(quot_s3) * (PROD_W+1)'(PCT_MAX));
	assign quot_fix = (rem >= (PROD_W+1)'(PCT_MAX)) ? quot_s3 + QUOT_W'(1) : quot_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy2) begin
				valid_s2 <= res_valid;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			res_s2 <= res;
			prod_s2 <= PROD_W'(reload) * PROD_W'(res.level);
		end
		if (rdy3) begin
			res_s3 <= res_s2;
			prod_s3 <= prod_s2;
			quot_s3 <= rprod[RPROD_W-1:RECIP_SHIFT];
		end
		if (rdy4) begin
			res_s4 <= res_s3;
			cmp_s4 <= quot_fix[15:0];
		end
	end

	assign out_ch.valid = valid_s4;
	assign out_ch.duty_percent = res_s4.level;
	assign out_ch.compare_value = cmp_s4;
	assign out_ch.ready_res = res_s4.done;

endmodule

### rtl/core/led_pattern_sequencer.sv
// LED pattern sequencer top level: configuration registers, pattern state
// machine and PWM compare pipeline. Uses lps_pkg, lps_if, lps_cfg, lps_seq, lps_scale.

// The block takes one request per clock cycle, unless the input stalls: a 1 ms
// tick, a set-mode command or a show-code command, and returns one result for
// each: the LED duty in percent, the PWM compare value reload * duty / 100 and
// a flag that is high once the pattern has completed. The pattern state updates
// in the cycle a request is accepted; the result is registered in the sequencer
// stage and then passes the multiply and the two-step divide by 100 of the compare
// pipeline. Every stage holds its data under back-pressure; while results are
// not taken, four requests fill the pipeline before the input stalls.
// Registers are written over the APB port at byte address 4 * index and
// should only change while no request is in flight.
module led_pattern_sequencer (
	input logic clk,
	input logic arst_n,
	lps_in_if.sink in_ch,
	lps_out_if.source out_ch,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [lps_pkg::ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import lps_pkg::*;

	cfg_t cfg;
	logic res_valid;
	logic res_ready;
	seq_res_t res;

	// Configuration registers.
	lps_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	// Pattern state machine.
	lps_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.cfg(cfg),
		.next_ready(res_ready),
		.res_valid(res_valid),
		.res(res)
	);

	// Compare scaling and output register.
	lps_scale u_scale (
		.clk(clk),
		.arst_n(arst_n),
		.res_valid(res_valid),
		.res(res),
		.reload(cfg.reload),
		.res_ready(res_ready),
		.out_ch(out_ch)
	);

endmodule
